@@ design/z85_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// z85_pkg: shared types and constants of the Z85 stream encoder
// Holds the job record between the byte gatherer and the digit unit, the
// reciprocal constant used to divide by 85, and the 85-symbol alphabet.
// ----------------------------------------------------------------------------
package z85_pkg;

  localparam int DIGITS       = 5;
  localparam int ALPHA_LEN    = 85;
  localparam int QUEUE_DEPTH  = 2;

  // floor(n / 85) == (n * RECIP_85) >> RECIP_SHIFT for every 32-bit n
  localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
  localparam int          RECIP_SHIFT = 38;
  // a 32-bit value divided by 85 fits in 26 bits
  localparam int          QUOT_W      = 26;

  localparam logic [8*ALPHA_LEN-1:0] ALPHABET =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  // one group of four bytes, or a length error marker
  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        err;
  } job_t;

  // map a base-85 digit to its ascii character
  function automatic logic [6:0] z85_char(input logic [6:0] digit);
    logic [6:0] pos;
    logic [7:0] ch;
    pos = 7'(ALPHA_LEN - 1) - digit;
    ch  = ALPHABET[{pos, 3'b000} +: 8];
    if (digit > 7'(ALPHA_LEN - 1)) begin
      return 7'd0;
    end
    return ch[6:0];
  endfunction

endpackage
`default_nettype wire

@@ design/z85_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// z85_if: valid/ready channels of the Z85 stream encoder
// One channel carries raw bytes in, the other carries characters out.
// ----------------------------------------------------------------------------
interface z85_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_end;

  modport source (output valid, output data_byte, output message_end, input ready);
  modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

interface z85_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol;
  logic       group_end;
  logic       message_end_res;
  logic       length_error;

  modport source (output valid, output symbol, output group_end,
                  output message_end_res, output length_error, input ready);
  modport sink   (input valid, input symbol, input group_end,
                  input message_end_res, input length_error, output ready);
endinterface
`default_nettype wire

@@ design/z85_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// z85_front: byte gatherer
// Packs four bytes big-endian into one job, or flags a short final group.
// ----------------------------------------------------------------------------
module z85_front (
  input  wire logic          clk,
  input  wire logic          rst,
  z85_in_if.sink             in_ch,
  input  wire logic          q_full,
  output logic               push,
  output z85_pkg::job_t      job
);
  import z85_pkg::*;

  logic [23:0] partial_value;
  logic [1:0]  byte_position;
  logic        take;
  logic        fourth;

  // accept whenever the job queue has room
  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign fourth      = (byte_position == 2'd3);
  assign push        = take && (fourth || in_ch.message_end);

  // job record
  assign job.value = {partial_value, in_ch.data_byte};
  assign job.last  = in_ch.message_end;
  assign job.err   = in_ch.message_end && !fourth;

  // gather state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      byte_position <= '0;
    end else if (take) begin
      if (fourth || in_ch.message_end) begin
        partial_value <= '0;
        byte_position <= '0;
      end else begin
        partial_value <= {partial_value[15:0], in_ch.data_byte};
        byte_position <= byte_position + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/z85_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// z85_queue: job queue
// Small first-in first-out buffer between the gatherer and the digit unit.
// ----------------------------------------------------------------------------
module z85_queue #(
  parameter int DEPTH = z85_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire z85_pkg::job_t push_job,
  output logic               full,
  output logic               valid,
  input  wire logic          pop,
  output z85_pkg::job_t      pop_job
);
  import z85_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign pop_job = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ design/z85_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// z85_back: digit unit and character emitter
// Splits each 32-bit value into five base-85 digits, least significant first,
// one per cycle, then sends the characters most significant first.
// ----------------------------------------------------------------------------
module z85_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire z85_pkg::job_t q_job,
  output logic               pop,
  z85_out_if.source          out_ch
);
  import z85_pkg::*;

  // converter state
  logic              conv_busy;
  logic [2:0]        conv_cnt;
  logic              conv_last;
  logic              conv_err;
  logic [31:0]       n_prev;
  logic [QUOT_W-1:0] quot;
  logic [6:0]        digits [DIGITS];

  // emitter state
  logic              emit_busy;
  logic [2:0]        emit_idx;
  logic              emit_last;
  logic              emit_err;
  logic [6:0]        emit_buf [DIGITS];

  logic              conv_done;
  logic              conv_step;
  logic              conv_free;
  logic              emit_final;
  logic              emit_take;
  logic              emit_free;
  logic              handoff;
  logic [31:0]       mul_a;
  logic [63:0]       prod;
  logic [31:0]       quot_ext;
  logic [31:0]       times85;
  logic [31:0]       rem;
  logic [2:0]        sel;

  // handshake between converter, emitter and queue
  assign conv_done  = conv_busy && (conv_err || conv_cnt == 3'(DIGITS));
  assign conv_step  = conv_busy && !conv_err && (conv_cnt != 3'(DIGITS));
  assign emit_final = emit_err || (emit_idx == 3'(DIGITS - 1));
  assign emit_take  = out_ch.valid && out_ch.ready;
  assign emit_free  = !emit_busy || (emit_take && emit_final);
  assign handoff    = conv_done && emit_free;
  assign conv_free  = !conv_busy || handoff;
  assign pop        = q_valid && conv_free;

  // reciprocal multiply: next quotient by 85
  assign mul_a = pop ? q_job.value : {{(32 - QUOT_W){1'b0}}, quot};
  assign prod  = {32'b0, mul_a} * {32'b0, RECIP_85};

  // remainder of the previous value: n - 85 * q
  assign quot_ext = {{(32 - QUOT_W){1'b0}}, quot};
  assign times85  = (quot_ext << 6) + (quot_ext << 4) + (quot_ext << 2) + quot_ext;
  assign rem      = n_prev - times85;

  // converter control
  always_ff @(posedge clk) begin
    if (rst) begin
      conv_busy <= 1'b0;
      conv_cnt  <= '0;
    end else if (pop) begin
      conv_busy <= 1'b1;
      conv_cnt  <= '0;
    end else if (handoff) begin
      conv_busy <= 1'b0;
    end else if (conv_step) begin
      conv_cnt <= conv_cnt + 3'd1;
    end
  end

  // converter datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      n_prev    <= q_job.value;
      quot      <= prod[RECIP_SHIFT +: QUOT_W];
      conv_last <= q_job.last;
      conv_err  <= q_job.err;
    end else if (conv_step) begin
      digits[conv_cnt] <= rem[6:0];
      n_prev           <= quot_ext;
      quot             <= prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  // emitter control
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy <= 1'b0;
      emit_idx  <= '0;
    end else if (handoff) begin
      emit_busy <= 1'b1;
      emit_idx  <= '0;
    end else if (emit_take) begin
      if (emit_final) begin
        emit_busy <= 1'b0;
      end else begin
        emit_idx <= emit_idx + 3'd1;
      end
    end
  end

  // emitter payload
  always_ff @(posedge clk) begin
    if (handoff) begin
      emit_buf  <= digits;
      emit_last <= conv_last;
      emit_err  <= conv_err;
    end
  end

  // characters go out most significant digit first
  assign sel                    = 3'(DIGITS - 1) - emit_idx;
  assign out_ch.valid           = emit_busy;
  assign out_ch.symbol          = emit_err ? 7'd0 : z85_char(emit_buf[sel]);
  assign out_ch.group_end       = emit_final;
  assign out_ch.message_end_res = emit_last && emit_final;
  assign out_ch.length_error    = emit_err;

endmodule
`default_nettype wire

@@ design/z85_stream_encoder_top.sv @@
`default_nettype none
// Path: a group's job enters the queue when its fourth byte is taken, is
//   popped by the digit unit and, with its digits done, passes to the emitter;
//   a length error job skips the digit steps. Bytes are taken one per cycle
//   while the job queue has room; a group holds the digit unit for a load plus
//   one multiply per digit, and the next is popped only as it passes on.
// Reset: synchronous rst clears the gatherer, the queue and both back stages.
// ----------------------------------------------------------------------------
// z85_stream_encoder_top: Z85 stream encoder
// Gathers bytes into 32-bit groups and emits five base-85 characters each.
// ----------------------------------------------------------------------------
module z85_stream_encoder_top #(
  parameter int QUEUE_DEPTH = z85_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  z85_in_if.sink    bytes,
  z85_out_if.source chars
);
  import z85_pkg::*;

  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t push_job;
  job_t pop_job;

  // byte gatherer
  z85_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (bytes),
    .q_full (q_full),
    .push   (q_push),
    .job    (push_job)
  );

  // job queue
  z85_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_job  (pop_job)
  );

  // digit unit and emitter
  z85_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (pop_job),
    .pop     (q_pop),
    .out_ch  (chars)
  );

`ifndef NO_ASSERTIONS
  // no job is written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // no job is taken from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("job popped from empty queue");

  // a length error result closes both the group and the message
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.length_error) |->
      (chars.group_end && chars.message_end_res && chars.symbol == 7'd0))
    else $error("malformed length error result");

  // an error job reaches the output as soon as the emitter is free
  a_err_pass: assert property (@(posedge clk) disable iff (rst)
    (q_pop && pop_job.err && !chars.valid) |=> ##1 chars.valid)
    else $error("length error result not offered");
`endif

endmodule
`default_nettype wire

@@ sim/z85_stream_encoder_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// z85_stream_encoder_top_test: self-checking bench for the Z85 stream encoder
// Drives raw bytes through the input channel and checks every character on
// the output channel against an in-bench base-85 encoder or known text. A short
// directed table covers known groups, extremes and short-message errors. Random
// messages follow under four idling phases on both channels.
// ----------------------------------------------------------------------------
module z85_stream_encoder_top_test;

  // one output character as seen on the chars channel
  typedef struct packed {
    logic [6:0] symbol;
    logic       group_end;
    logic       message_end_res;
    logic       length_error;
  } char_rec_t;

  // how a directed row gets its expected characters
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_TEXT,
    CHK_LEN_ERR
  } check_kind_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    check_kind_t kind;
    logic [39:0] text;
  } step_t;

  localparam int          DIRECTED_ROWS = 26;
  localparam int          PHASE_ITEMS   = 100;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [39:0] NO_TEXT       = '0;
  localparam logic [31:0] POW85_4       = 32'd52200625;
  localparam logic [8*85-1:0] Z85_SYMBOLS =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  logic clk = 1'b0;
  logic rst;

  int idle_pct  = 0;
  int stall_pct = 0;
  int mismatch_count = 0;

  // bench copy of the encoder state
  logic [23:0] gather_word  = '0;
  logic [1:0]  gather_count = '0;

  char_rec_t expected_chars[$];
  step_t     directed_steps [DIRECTED_ROWS];

  z85_in_if  in_ch ();
  z85_out_if out_ch ();

  z85_stream_encoder_top dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (in_ch),
    .chars (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // advance the encoder by one byte, queueing the characters it yields
  function automatic void encode_byte(input logic [7:0] b, input logic e,
                                      input logic state_only);
    logic [31:0] word;
    logic [31:0] divisor;
    logic [6:0]  digit;
    char_rec_t   rec;
    int          k;
    if (gather_count == 2'd3) begin
      word    = {gather_word, b};
      divisor = POW85_4;
      for (k = 0; k < 5; k++) begin
        digit               = 7'((word / divisor) % 32'd85);
        rec.symbol          = Z85_SYMBOLS[8*(84 - int'(digit)) +: 7];
        rec.group_end       = (k == 4);
        rec.message_end_res = (k == 4) && e;
        rec.length_error    = 1'b0;
        if (!state_only) expected_chars.push_back(rec);
        divisor = divisor / 32'd85;
      end
      gather_word  = '0;
      gather_count = '0;
    end else if (e) begin
      rec = '{symbol: 7'd0, group_end: 1'b1, message_end_res: 1'b1, length_error: 1'b1};
      if (!state_only) expected_chars.push_back(rec);
      gather_word  = '0;
      gather_count = '0;
    end else begin
      gather_word  = {gather_word[15:0], b};
      gather_count = gather_count + 2'd1;
    end
  endfunction

  // offer one byte, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.message_end <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random messages: mostly whole groups, some short, some loose bytes
  task automatic run_random(input int budget);
    int         sent;
    int         len;
    int         shape;
    int         k;
    logic [7:0] b;
    logic       e;
    sent = 0;
    while (sent < budget) begin
      shape = $urandom_range(99);
      if (shape < 70) len = 4 * $urandom_range(1, 4);
      else if (shape < 85) len = 4 * $urandom_range(0, 2) + $urandom_range(1, 3);
      else len = $urandom_range(1, 6);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(9))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom_range(255));
        endcase
        if (shape < 85) e = (k == len - 1);
        else e = ($urandom_range(3) == 0);
        encode_byte(b, e, 1'b0);
        send_byte(b, e);
      end
      sent += len;
    end
  endtask

  task automatic flag_mismatch(input string what, input char_rec_t want,
                               input char_rec_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t %s: exp sym=%02h gend=%b mend=%b lerr=%b", $realtime, what,
               want.symbol, want.group_end, want.message_end_res, want.length_error);
      $display("%0t %s: got sym=%02h gend=%b mend=%b lerr=%b", $realtime, what,
               got.symbol, got.group_end, got.message_end_res, got.length_error);
    end
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // character checker
  always @(posedge clk) begin
    char_rec_t got;
    char_rec_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{symbol: out_ch.symbol, group_end: out_ch.group_end,
              message_end_res: out_ch.message_end_res,
              length_error: out_ch.length_error};
      if (expected_chars.size() == 0) begin
        flag_mismatch("unexpected character", '0, got);
      end else begin
        want = expected_chars.pop_front();
        if (got.symbol !== want.symbol || got.group_end !== want.group_end ||
            got.message_end_res !== want.message_end_res ||
            got.length_error !== want.length_error) begin
          flag_mismatch("character mismatch", want, got);
        end
      end
    end
  end

  initial begin
    step_t     row;
    char_rec_t rec;
    int        i;
    int        k;
    int        phase;

    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = '0;
    in_ch.message_end = 1'b0;
    out_ch.ready      = 1'b0;

    directed_steps = '{
      // all-zero group right after reset
      '{8'h00, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'h00, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'h00, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'h00, 1'b0, CHK_TEXT,  "00000"},
      // all-ones group closing a message
      '{8'hFF, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'hFF, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'hFF, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'hFF, 1'b1, CHK_TEXT,  "%nSc0"},
      // well-known two-group vector
      '{8'h86, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'h4F, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'hD2, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'h6F, 1'b0, CHK_TEXT,  "Hello"},
      '{8'hB5, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'h59, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'hF7, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'h5B, 1'b1, CHK_TEXT,  "World"},
      // end mark on first, second and third byte of a group
      '{8'hA5, 1'b1, CHK_LEN_ERR, NO_TEXT},
      '{8'h12, 1'b0, CHK_MODEL,   NO_TEXT},
      '{8'h34, 1'b1, CHK_LEN_ERR, NO_TEXT},
      '{8'h01, 1'b0, CHK_MODEL,   NO_TEXT},
      '{8'h02, 1'b0, CHK_MODEL,   NO_TEXT},
      '{8'h03, 1'b1, CHK_LEN_ERR, NO_TEXT},
      // mixed group without an end mark
      '{8'h7F, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'h80, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'h01, 1'b0, CHK_MODEL, NO_TEXT},
      '{8'hFE, 1'b0, CHK_MODEL, NO_TEXT}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_steps[i];
      encode_byte(row.data, row.last, row.kind != CHK_MODEL);
      if (row.kind == CHK_TEXT) begin
        for (k = 0; k < 5; k++) begin
          rec.symbol          = row.text[8*(4 - k) +: 7];
          rec.group_end       = (k == 4);
          rec.message_end_res = (k == 4) && row.last;
          rec.length_error    = 1'b0;
          expected_chars.push_back(rec);
        end
      end else if (row.kind == CHK_LEN_ERR) begin
        expected_chars.push_back('{symbol: 7'd0, group_end: 1'b1,
                                   message_end_res: 1'b1, length_error: 1'b1});
      end
      send_byte(row.data, row.last);
    end

    // random phases with different idling on each side
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      run_random(PHASE_ITEMS);
      // hold the sender until every queued character has come out
      in_ch.valid <= 1'b0;
      while (expected_chars.size() != 0) @(negedge clk);
      repeat (10) @(negedge clk);
    end

    // let any stray character show up
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ z85_stream_encoder_top.f @@
design/z85_pkg.sv
design/z85_if.sv
design/z85_front.sv
design/z85_queue.sv
design/z85_back.sv
design/z85_stream_encoder_top.sv
sim/z85_stream_encoder_top_test.sv
